// ===== hw/rtl/sps_pkg.sv =====
// shared constants, register codes and types for the stepper position step pulser
// used by every module under hw/rtl
package sps_pkg;

  // widths fixed by the item fields and registers
  localparam int RAW_W      = 12;
  localparam int ANGLE_W    = 9;
  localparam int DELAY_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // defaults for the top level parameters
  localparam int RAW_FULL_SCALE_DEF = 4055;
  localparam int COUNT_WIDTH_DEF    = 16;
  localparam int FIFO_DEPTH_DEF     = 8;

  // one full turn in degrees, also the error clamp
  localparam logic [ANGLE_W-1:0] ANGLE_SPAN = 9'd360;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 9'h1FF;
  localparam logic [ANGLE_W-1:0] HOME_ANGLE = 9'd150;

  // raw reading times the span fits in this many bits
  localparam int RAW_PROD_W = RAW_W + ANGLE_W;

  // exact divide by the span: floor(x * M / 2^SH) for x below 2^SPAN_DIV_IN_W
  localparam int                SPAN_DIV_IN_W = 25;
  localparam int                SPAN_DIV_M_W  = 26;
  localparam int                SPAN_DIV_SH   = 34;
  localparam logic [SPAN_DIV_M_W-1:0] SPAN_DIV_M = 26'd47721859;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOLERANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANGLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGLE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_DELAY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_DELAY      = 3'd4;

  // register reset values
  localparam logic [ANGLE_W-1:0] RST_ANGLE_TOLERANCE = 9'd0;
  localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE       = 9'd5;
  localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE       = 9'd355;
  localparam logic [DELAY_W-1:0] RST_FAST_DELAY      = 16'd100;
  localparam logic [DELAY_W-1:0] RST_SLOW_DELAY      = 16'd2000;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_tolerance;
    logic [ANGLE_W-1:0] angle_lo;
    logic [ANGLE_W-1:0] angle_hi;
    logic [DELAY_W-1:0] fast_delay;
    logic [DELAY_W-1:0] slow_delay;
  } sps_cfg_t;

  // classified tick handed from the front to the back
  typedef struct packed {
    logic               direction;
    logic               limited;
    logic [ANGLE_W-1:0] angle;
    logic [DELAY_W-1:0] delay;
    logic               rejected;
  } sps_item_t;

endpackage

// ===== hw/rtl/sps_cfg_regs.sv =====
// configuration register file, one write port, no read-back
// depends on sps_pkg
module sps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output sps_pkg::sps_cfg_t                cfg_o
);

  sps_pkg::sps_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sps_pkg::REG_ANGLE_TOLERANCE: cfg_d.angle_tolerance = cfg_wdata_i[sps_pkg::ANGLE_W-1:0];
        sps_pkg::REG_MIN_ANGLE:       cfg_d.angle_lo        = cfg_wdata_i[sps_pkg::ANGLE_W-1:0];
        sps_pkg::REG_MAX_ANGLE:       cfg_d.angle_hi        = cfg_wdata_i[sps_pkg::ANGLE_W-1:0];
        sps_pkg::REG_FAST_DELAY:      cfg_d.fast_delay      = cfg_wdata_i[sps_pkg::DELAY_W-1:0];
        sps_pkg::REG_SLOW_DELAY:      cfg_d.slow_delay      = cfg_wdata_i[sps_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_tolerance <= sps_pkg::RST_ANGLE_TOLERANCE;
      cfg_q.angle_lo        <= sps_pkg::RST_MIN_ANGLE;
      cfg_q.angle_hi        <= sps_pkg::RST_MAX_ANGLE;
      cfg_q.fast_delay      <= sps_pkg::RST_FAST_DELAY;
      cfg_q.slow_delay      <= sps_pkg::RST_SLOW_DELAY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/sps_front.sv =====
// front end: accepts ticks, updates the target, converts the angle,
// picks direction and computes the step half-period over four stages; uses sps_pkg
module sps_front #(
  parameter int RAW_FULL_SCALE = sps_pkg::RAW_FULL_SCALE_DEF,
  parameter int FIFO_DEPTH     = sps_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sps_pkg::sps_cfg_t                      cfg_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [sps_pkg::RAW_W-1:0]              raw_angle_i,
  input  logic                                   read_ok_i,
  input  logic                                   target_valid_i,
  input  logic [sps_pkg::ANGLE_W-1:0]            target_value_i,
  input  logic [$clog2(FIFO_DEPTH+1)-1:0]        queue_count_i,
  output logic                                   push_o,
  output sps_pkg::sps_item_t                     item_o
);

  localparam int AW     = sps_pkg::ANGLE_W;
  localparam int DW     = sps_pkg::DELAY_W;
  localparam int PW     = sps_pkg::RAW_PROD_W;
  localparam int CNT_W  = $clog2(FIFO_DEPTH+1);
  localparam int SUM_W  = CNT_W + 3;
  // exact reciprocal for the raw full scale
  localparam int ANG_L  = $clog2(RAW_FULL_SCALE);
  localparam int ANG_SH = PW + ANG_L;
  localparam int ANG_MW = PW + 2;
  localparam int ANG_PW = PW + ANG_MW;
  localparam longint unsigned ANG_M =
    ((64'd1 << ANG_SH) + 64'(RAW_FULL_SCALE) - 64'd1) / 64'(RAW_FULL_SCALE);
  localparam int DIV_PW = sps_pkg::SPAN_DIV_IN_W + sps_pkg::SPAN_DIV_M_W;

  logic accept;

  logic [AW-1:0] target_q, target_d;
  logic          dir_q, dir_d;

  // stage 1
  logic          v1_q;
  logic [PW-1:0] prod1_q;
  logic [AW-1:0] tgt1_q;
  logic          rej1_q;
  // stage 2
  logic          v2_q;
  logic [AW-1:0] ang2_q, tgt2_q;
  logic          rej2_q;
  // stage 3
  logic          v3_q;
  logic [AW-1:0] ang3_q, err3_q;
  logic          dir3_q, lim3_q, rej3_q;
  // stage 4
  logic                              v4_q;
  logic [sps_pkg::SPAN_DIV_IN_W-1:0] mag4_q;
  logic                              neg4_q;
  logic [AW-1:0]                     ang4_q;
  logic                              dir4_q, lim4_q, rej4_q;

  logic          tgt_ok;
  logic [PW-1:0] prod1_d;

  logic [ANG_PW-1:0] ang_full;
  logic [AW-1:0]     ang2_d;

  logic signed [AW+1:0] cur_s, tgt_lo_s, tgt_hi_s, min_s, max_s;
  logic                 fwd, rev;
  logic [AW-1:0]        abs_err, err3_d;

  logic [DW-1:0]                     diff_mag;
  logic [sps_pkg::SPAN_DIV_IN_W-1:0] mag4_d;

  logic [DIV_PW-1:0] quot_full;
  logic [DW-1:0]     quot;

  logic [SUM_W-1:0] in_flight;

  // credit check: every tick in the pipe already owns a queue slot
  assign in_flight = SUM_W'(v1_q) + SUM_W'(v2_q) + SUM_W'(v3_q) + SUM_W'(v4_q);
  assign in_stall_o = (SUM_W'(queue_count_i) + in_flight) >= SUM_W'(FIFO_DEPTH);
  assign accept = in_valid_i && !in_stall_o;

  // target update and raw product
  always_comb begin
    tgt_ok   = (target_value_i >= cfg_i.angle_lo) && (target_value_i <= cfg_i.angle_hi);
    target_d = target_q;
    if (accept && target_valid_i && tgt_ok) begin
      target_d = target_value_i;
    end
    prod1_d = read_ok_i ? (PW'(raw_angle_i) * PW'(sps_pkg::ANGLE_SPAN)) : '0;
  end

  // angle in whole degrees, saturated
  always_comb begin
    ang_full = (ANG_PW'(prod1_q) * ANG_PW'(ANG_M[ANG_MW-1:0])) >> ANG_SH;
    ang2_d   = (ang_full > ANG_PW'(sps_pkg::ANGLE_MAX)) ? sps_pkg::ANGLE_MAX : ang_full[AW-1:0];
  end

  // direction against target +/- tolerance and the limits
  always_comb begin
    cur_s    = $signed({2'b00, ang2_q});
    min_s    = $signed({2'b00, cfg_i.angle_lo});
    max_s    = $signed({2'b00, cfg_i.angle_hi});
    tgt_lo_s = $signed({2'b00, tgt2_q}) - $signed({2'b00, cfg_i.angle_tolerance});
    tgt_hi_s = $signed({2'b00, tgt2_q}) + $signed({2'b00, cfg_i.angle_tolerance});
    fwd      = (cur_s < tgt_lo_s) && (cur_s > min_s);
    rev      = !fwd && (cur_s > tgt_hi_s) && (cur_s < max_s);
    dir_d    = dir_q;
    if (v2_q && fwd) begin
      dir_d = 1'b0;
    end else if (v2_q && rev) begin
      dir_d = 1'b1;
    end
    abs_err = (ang2_q >= tgt2_q) ? (ang2_q - tgt2_q) : (tgt2_q - ang2_q);
    err3_d  = (abs_err > sps_pkg::ANGLE_SPAN) ? sps_pkg::ANGLE_SPAN : abs_err;
  end

  // error times delay span, kept as sign and magnitude
  always_comb begin
    diff_mag = (cfg_i.fast_delay >= cfg_i.slow_delay) ? (cfg_i.fast_delay - cfg_i.slow_delay)
                                                      : (cfg_i.slow_delay - cfg_i.fast_delay);
    mag4_d   = sps_pkg::SPAN_DIV_IN_W'(err3_q) * sps_pkg::SPAN_DIV_IN_W'(diff_mag);
  end

  // divide by the span, truncating toward zero, then offset from slow delay
  always_comb begin
    quot_full = (DIV_PW'(mag4_q) * DIV_PW'(sps_pkg::SPAN_DIV_M)) >> sps_pkg::SPAN_DIV_SH;
    quot      = quot_full[DW-1:0];
    item_o.direction = dir4_q;
    item_o.limited   = lim4_q;
    item_o.angle     = ang4_q;
    item_o.delay     = neg4_q ? (cfg_i.slow_delay - quot) : (cfg_i.slow_delay + quot);
    item_o.rejected  = rej4_q;
  end

  assign push_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= sps_pkg::HOME_ANGLE;
      dir_q    <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      v4_q     <= 1'b0;
    end else begin
      target_q <= target_d;
      dir_q    <= dir_d;
      v1_q     <= accept;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      v4_q     <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    tgt1_q  <= target_d;
    rej1_q  <= target_valid_i && !tgt_ok;

    ang2_q  <= ang2_d;
    tgt2_q  <= tgt1_q;
    rej2_q  <= rej1_q;

    ang3_q  <= ang2_q;
    err3_q  <= err3_d;
    dir3_q  <= dir_d;
    lim3_q  <= !fwd && !rev;
    rej3_q  <= rej2_q;

    mag4_q  <= mag4_d;
    neg4_q  <= cfg_i.fast_delay < cfg_i.slow_delay;
    ang4_q  <= ang3_q;
    dir4_q  <= dir3_q;
    lim4_q  <= lim3_q;
    rej4_q  <= rej3_q;
  end

endmodule

// ===== hw/rtl/sps_queue.sv =====
// short queue of classified ticks between front and back
// depends on sps_pkg for the entry type
module sps_queue #(
  parameter int FIFO_DEPTH = sps_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  sps_pkg::sps_item_t                item_i,
  input  logic                              pop_i,
  output sps_pkg::sps_item_t                item_o,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]   count_o
);

  // depth of two or more
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH+1);

  sps_pkg::sps_item_t entry_q [FIFO_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/sps_back.sv =====
// back end: tick counter, step toggle and the output register
// depends on sps_pkg for the entry type
module sps_back #(
  parameter int COUNT_WIDTH = sps_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  sps_pkg::sps_item_t              item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            step_level_o,
  output logic                            direction_o,
  output logic                            limited_o,
  output logic [sps_pkg::ANGLE_W-1:0]     current_angle_o,
  output logic [sps_pkg::DELAY_W-1:0]     step_delay_o,
  output logic                            target_rejected_o
);

  localparam int CMP_W = (COUNT_WIDTH > sps_pkg::DELAY_W) ? COUNT_WIDTH : sps_pkg::DELAY_W;

  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                   step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic                   toggle;

  sps_pkg::sps_item_t out_item_q;

  assign pop_o = item_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    // saturating tick count
    elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
    toggle      = !item_i.limited && (CMP_W'(elapsed_inc) >= CMP_W'(item_i.delay));
    elapsed_d   = elapsed_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      elapsed_d   = toggle ? '0 : elapsed_inc;
      step_d      = step_q ^ toggle;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '1;
      step_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      elapsed_q   <= elapsed_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_item_q <= item_i;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_level_o      = step_q;
  assign direction_o       = out_item_q.direction;
  assign limited_o         = out_item_q.limited;
  assign current_angle_o   = out_item_q.angle;
  assign step_delay_o      = out_item_q.delay;
  assign target_rejected_o = out_item_q.rejected;

endmodule

// ===== hw/rtl/stepper_position_step_pulser_top.sv =====
// path: a tick passes the four front stages, the queue and the back end output register
// throughput: one tick per cycle unless a stall holds it, set by the back end tick counter
// front stages hold queue credits; input stalls when queued plus staged ticks hit the depth
// reset: registers to defaults, target 150, direction ccw, step low, tick count saturated
// no clearing pass; ticks are taken from the first cycle after reset
module stepper_position_step_pulser_top #(
  parameter int RAW_FULL_SCALE = sps_pkg::RAW_FULL_SCALE_DEF,
  parameter int COUNT_WIDTH    = sps_pkg::COUNT_WIDTH_DEF,
  parameter int FIFO_DEPTH     = sps_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sps_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sps_pkg::RAW_W-1:0]        raw_angle_i,
  input  logic                             read_ok_i,
  input  logic                             target_valid_i,
  input  logic [sps_pkg::ANGLE_W-1:0]      target_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             step_level_o,
  output logic                             direction_o,
  output logic                             limited_o,
  output logic [sps_pkg::ANGLE_W-1:0]      current_angle_o,
  output logic [sps_pkg::DELAY_W-1:0]      step_delay_o,
  output logic                             target_rejected_o
);

  localparam int CNT_W = $clog2(FIFO_DEPTH+1);

  sps_pkg::sps_cfg_t  cfg;
  sps_pkg::sps_item_t push_item, head_item;
  logic               push, pop;
  logic [CNT_W-1:0]   q_count;

  sps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sps_front #(
    .RAW_FULL_SCALE (RAW_FULL_SCALE),
    .FIFO_DEPTH     (FIFO_DEPTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_angle_i    (raw_angle_i),
    .read_ok_i      (read_ok_i),
    .target_valid_i (target_valid_i),
    .target_value_i (target_value_i),
    .queue_count_i  (q_count),
    .push_o         (push),
    .item_o         (push_item)
  );

  sps_queue #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .count_o (q_count)
  );

  sps_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (q_count != '0),
    .item_i            (head_item),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .step_level_o      (step_level_o),
    .direction_o       (direction_o),
    .limited_o         (limited_o),
    .current_angle_o   (current_angle_o),
    .step_delay_o      (step_delay_o),
    .target_rejected_o (target_rejected_o)
  );

  // the credit check must keep the queue from ever filling past its depth
  a_queue_no_overflow: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count < CNT_W'(FIFO_DEPTH))
  ) else $error("queue push while full");

  a_pop_nonempty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    pop |-> (q_count != '0)
  ) else $error("queue pop while empty");

  // a held motor leaves the step level alone
  a_limited_holds_step: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (pop && head_item.limited) |=> (step_level_o == $past(step_level_o))
  ) else $error("step toggled on a limited tick");

endmodule
